### hw/rtl/gcvfs_pkg.sv
// Shared types, constants and register map for the GC victim file selector.
package gcvfs_pkg;

  // Width of each field and register.
  localparam int FileBytesW = 40;
  localparam int LivePagesW = 24;
  localparam int RateW      = 17;
  localparam int CountW     = 16;
  localparam int BytesTotW  = 48;
  localparam int PagesTotW  = 32;
  localparam int CfgDataW   = 40;
  localparam int CfgIdxW    = 3;

  // Q16 product of rate and file size, and the 13/20 ratio products.
  localparam int ProdW  = RateW + FileBytesW;
  localparam int Ratio20W = FileBytesW + 5;

  // Candidates needed before selection may stop.
  localparam logic [CountW-1:0] MIN_CANDIDATES = 16'd2;

  // Register reset values.
  localparam logic [RateW-1:0]      MAX_RATE_RST    = 17'd22938;
  localparam logic [FileBytesW-1:0] SMALL_BYTES_RST = 40'd1048576;
  localparam logic [FileBytesW-1:0] TARGET_BYTES_RST = 40'd134217728;
  localparam logic [CountW-1:0]     MIN_FILES_RST   = 16'd10;
  localparam logic [FileBytesW-1:0] MIN_BYTES_RST   = 40'd134217728;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_RATE     = 3'd0,
    REG_SMALL_BYTES  = 3'd1,
    REG_TARGET_BYTES = 3'd2,
    REG_MIN_FILES    = 3'd3,
    REG_MIN_BYTES    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_SKIP    = 2'd0,
    VERDICT_CAND    = 2'd1,
    VERDICT_EMPTY   = 2'd2,
    VERDICT_IGNORED = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [FileBytesW-1:0] file_bytes;
    logic [FileBytesW-1:0] live_bytes;
    logic [LivePagesW-1:0] live_pages;
    logic                  being_written;
    logic                  last_file;
  } in_t;

  typedef struct packed {
    verdict_t             verdict;
    logic                 selection_stopped;
    logic [CountW-1:0]    candidates_so_far;
    logic [BytesTotW-1:0] bytes_to_move;
    logic [PagesTotW-1:0] pages_to_move;
    logic                 run_compaction;
    logic                 scan_done;
  } out_t;

  typedef struct packed {
    logic [RateW-1:0]      max_valid_rate_q16;
    logic [FileBytesW-1:0] small_file_bytes;
    logic [FileBytesW-1:0] target_file_bytes;
    logic [CountW-1:0]     min_files;
    logic [FileBytesW-1:0] min_bytes;
  } cfg_t;

  // Product stage contents.
  typedef struct packed {
    logic [ProdW-1:0]      rate_prod;
    logic [Ratio20W-1:0]   live_x20;
    logic [Ratio20W-1:0]   file_x13;
    logic [FileBytesW-1:0] live_bytes;
    logic [LivePagesW-1:0] live_pages;
    logic                  file_zero;
    logic                  file_small;
    logic                  being_written;
    logic                  last_file;
  } prod_t;

  // Classified file, handed to the accumulator.
  typedef struct packed {
    logic                  cand;
    logic                  live_zero;
    logic                  low_ratio;
    logic [FileBytesW-1:0] live_bytes;
    logic [LivePagesW-1:0] live_pages;
    logic                  last_file;
  } cls_t;

endpackage

### hw/rtl/gcvfs_skid.sv
// Input register with skid entry so in_ready comes straight from a flop.
module gcvfs_skid
  import gcvfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic s_valid,
  input  logic s_ready,
  output in_t  s_data
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  in_t  main_r, main_nxt;
  in_t  skid_r, skid_nxt;
  logic push, pop;

  assign in_ready = !skid_valid_r;
  assign s_valid  = main_valid_r;
  assign s_data   = main_r;

  assign push = in_valid && !skid_valid_r;
  assign pop  = main_valid_r && s_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      main_valid_nxt = 1'b0;
    end
    if (skid_valid_r && pop) begin
      main_nxt       = skid_r;
      main_valid_nxt = 1'b1;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = in_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = in_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### hw/rtl/gcvfs_classify.sv
// Two-stage classifier: rate products, then candidate decision.
module gcvfs_classify
  import gcvfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic s_valid,
  output logic s_ready,
  input  in_t  s_data,
  output logic cls_valid,
  input  logic cls_ready,
  output cls_t cls_data
);

  logic  p_valid_r, f_valid_r;
  logic  p_ready, f_ready;
  prod_t p_r, p_nxt;
  cls_t  f_r, f_nxt;
  logic  live_low;

  assign f_ready   = !f_valid_r || cls_ready;
  assign p_ready   = !p_valid_r || f_ready;
  assign s_ready   = p_ready;
  assign cls_valid = f_valid_r;
  assign cls_data  = f_r;

  // Stage 1: multiply and constant-ratio products.
  always_comb begin
    p_nxt.rate_prod     = ProdW'(cfg.max_valid_rate_q16) * ProdW'(s_data.file_bytes);
    p_nxt.live_x20      = (Ratio20W'(s_data.live_bytes) << 4)
                        + (Ratio20W'(s_data.live_bytes) << 2);
    p_nxt.file_x13      = (Ratio20W'(s_data.file_bytes) << 3)
                        + (Ratio20W'(s_data.file_bytes) << 2)
                        + Ratio20W'(s_data.file_bytes);
    p_nxt.live_bytes    = s_data.live_bytes;
    p_nxt.live_pages    = s_data.live_pages;
    p_nxt.file_zero     = (s_data.file_bytes == '0);
    p_nxt.file_small    = (s_data.file_bytes < cfg.small_file_bytes);
    p_nxt.being_written = s_data.being_written;
    p_nxt.last_file     = s_data.last_file;
  end

  // Stage 2: compares. Empty files have rate zero; empty size is never low.
  always_comb begin
    if (p_r.live_bytes == '0) begin
      live_low = (cfg.max_valid_rate_q16 != '0);
    end else begin
      live_low = !p_r.file_zero && ({1'b0, p_r.live_bytes, 16'd0} < p_r.rate_prod);
    end
    f_nxt.cand       = !p_r.being_written
                     && (live_low || p_r.file_small || cfg.max_valid_rate_q16[RateW-1]);
    f_nxt.live_zero  = (p_r.live_bytes == '0);
    f_nxt.low_ratio  = (p_r.live_x20 < p_r.file_x13);
    f_nxt.live_bytes = p_r.live_bytes;
    f_nxt.live_pages = p_r.live_pages;
    f_nxt.last_file  = p_r.last_file;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_r <= s_valid;
      end
      if (f_ready) begin
        f_valid_r <= p_valid_r;
      end
    end
    if (p_ready && s_valid) begin
      p_r <= p_nxt;
    end
    if (f_ready && p_valid_r) begin
      f_r <= f_nxt;
    end
  end

endmodule

### hw/rtl/gcvfs_accum.sv
// Scan totals, stop rule, compaction decision and result register.
module gcvfs_accum
  import gcvfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cls_valid,
  output logic cls_ready,
  input  cls_t cls_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [CountW-1:0]    cand_cnt_r, high_cnt_r, cand_upd, high_upd;
  logic [BytesTotW-1:0] gath_bytes_r, low_bytes_r, gath_upd, low_upd;
  logic [PagesTotW-1:0] gath_pages_r, pages_upd;
  logic                 stop_r, stop_upd;
  logic [BytesTotW:0]   gath_sum, low_sum;
  logic [PagesTotW:0]   pages_sum;
  logic                 stop_hit;
  logic                 run;
  verdict_t             verdict;
  logic                 out_valid_r;
  out_t                 out_r, out_nxt;
  logic                 fire;

  assign cls_ready = !out_valid_r || out_ready;
  assign fire      = cls_valid && cls_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign gath_sum  = {1'b0, gath_bytes_r} + (BytesTotW+1)'(cls_data.live_bytes);
  assign low_sum   = {1'b0, low_bytes_r} + (BytesTotW+1)'(cls_data.live_bytes);
  assign pages_sum = {1'b0, gath_pages_r} + (PagesTotW+1)'(cls_data.live_pages);

  always_comb begin
    cand_upd  = cand_cnt_r;
    high_upd  = high_cnt_r;
    gath_upd  = gath_bytes_r;
    low_upd   = low_bytes_r;
    pages_upd = gath_pages_r;
    stop_upd  = stop_r;
    stop_hit  = 1'b0;
    if (stop_r) begin
      verdict = VERDICT_IGNORED;
    end else if (!cls_data.cand) begin
      verdict = VERDICT_SKIP;
    end else if (cls_data.live_zero) begin
      verdict = VERDICT_EMPTY;
    end else begin
      verdict   = VERDICT_CAND;
      cand_upd  = (cand_cnt_r == '1) ? cand_cnt_r : cand_cnt_r + 1'b1;
      gath_upd  = gath_sum[BytesTotW] ? '1 : gath_sum[BytesTotW-1:0];
      pages_upd = pages_sum[PagesTotW] ? '1 : pages_sum[PagesTotW-1:0];
      if (cls_data.low_ratio) begin
        low_upd = low_sum[BytesTotW] ? '1 : low_sum[BytesTotW-1:0];
      end else begin
        high_upd = (high_cnt_r == '1) ? high_cnt_r : high_cnt_r + 1'b1;
      end
      // All high-ratio-free so far: count every byte; else only low-ratio bytes.
      if (high_upd == '0) begin
        stop_hit = (gath_upd >= BytesTotW'(cfg.target_file_bytes));
      end else begin
        stop_hit = (low_upd >= BytesTotW'(cfg.target_file_bytes));
      end
      if (stop_hit && (cand_upd >= MIN_CANDIDATES)) begin
        stop_upd = 1'b1;
      end
    end
    run = cls_data.last_file
       && ((cand_upd >= cfg.min_files)
        || ((cand_upd >= MIN_CANDIDATES) && (gath_upd >= BytesTotW'(cfg.min_bytes))));
    out_nxt.verdict           = verdict;
    out_nxt.selection_stopped = stop_upd;
    out_nxt.candidates_so_far = cand_upd;
    out_nxt.bytes_to_move     = gath_upd;
    out_nxt.pages_to_move     = pages_upd;
    out_nxt.run_compaction    = run;
    out_nxt.scan_done         = cls_data.last_file;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      cand_cnt_r   <= '0;
      high_cnt_r   <= '0;
      gath_bytes_r <= '0;
      low_bytes_r  <= '0;
      gath_pages_r <= '0;
      stop_r       <= 1'b0;
    end else begin
      if (cls_ready) begin
        out_valid_r <= cls_valid;
      end
      if (fire) begin
        if (cls_data.last_file) begin
          cand_cnt_r   <= '0;
          high_cnt_r   <= '0;
          gath_bytes_r <= '0;
          low_bytes_r  <= '0;
          gath_pages_r <= '0;
          stop_r       <= 1'b0;
        end else begin
          cand_cnt_r   <= cand_upd;
          high_cnt_r   <= high_upd;
          gath_bytes_r <= gath_upd;
          low_bytes_r  <= low_upd;
          gath_pages_r <= pages_upd;
          stop_r       <= stop_upd;
        end
      end
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

### hw/rtl/gc_victim_file_selector.sv
// Top level of the GC victim file selector: config registers and pipeline.
//
//   port group | dir | handshake            | beat contents
//   in_*       | in  | in_valid / in_ready  | in_t: one file descriptor
//   out_*      | out | out_valid / out_ready| out_t: verdict and running totals
//   cfg_*      | in  | cfg_we (no stall)    | register index + 40-bit data
//
// One file per cycle sustained while out_ready stays high. The input register loads at the
// accepting edge; the product, compare and result registers follow before out_valid rises.
// The scan totals sit in one register set updated in the result stage, so
// each file sees the totals left by the one before it.
// Reset (rst_n, sync) empties the pipeline, clears totals, loads register defaults.
// out_ready low fills the pipeline; the input skid entry then drops in_ready.
module gc_victim_file_selector
  import gcvfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic s_valid, s_ready;
  in_t  s_data;
  logic cls_valid, cls_ready;
  cls_t cls_data;

  // Config registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_valid_rate_q16 <= MAX_RATE_RST;
      cfg_r.small_file_bytes   <= SMALL_BYTES_RST;
      cfg_r.target_file_bytes  <= TARGET_BYTES_RST;
      cfg_r.min_files          <= MIN_FILES_RST;
      cfg_r.min_bytes          <= MIN_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_RATE:     cfg_r.max_valid_rate_q16 <= cfg_wdata[RateW-1:0];
        REG_SMALL_BYTES:  cfg_r.small_file_bytes   <= cfg_wdata[FileBytesW-1:0];
        REG_TARGET_BYTES: cfg_r.target_file_bytes  <= cfg_wdata[FileBytesW-1:0];
        REG_MIN_FILES:    cfg_r.min_files          <= cfg_wdata[CountW-1:0];
        REG_MIN_BYTES:    cfg_r.min_bytes          <= cfg_wdata[FileBytesW-1:0];
        default: ;
      endcase
    end
  end

  gcvfs_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data)
  );

  gcvfs_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data)
  );

  gcvfs_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Ignored files only occur once the stop rule has fired.
  a_ignored_means_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict == VERDICT_IGNORED) |-> out_data.selection_stopped)
    else $error("ignored verdict without stop");

  // Compaction decision only on the closing beat of a scan.
  a_run_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.scan_done |-> !out_data.run_compaction)
    else $error("run_compaction outside scan end");

  // A candidate beat always carries a nonzero candidate count.
  a_cand_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict == VERDICT_CAND) |-> (out_data.candidates_so_far != '0))
    else $error("candidate not counted");

  // Input backpressure only while the result register holds a beat.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty result register");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for gc_victim_file_selector: queued stimulus, predictor, scoreboard.
module testbench;
  import gcvfs_pkg::*;

  // Timing and run shape.
  localparam int ClkPeriod     = 8;
  localparam int QuietLimit    = 2000;   // cycles without any beat before we give up
  localparam int DrainCycles   = 8;      // pipeline is 4 deep
  localparam int PhaseFiles    = 180;    // random files per config phase
  localparam int RandomPhases  = 8;
  localparam int ByteSatFiles  = 260;    // enough max-size files to pin bytes and pages
  localparam int TailFiles     = 100;    // short scan of small dense candidates
  localparam int MaxShown      = 100;    // cap on printed mismatch lines

  localparam logic [RateW-1:0]      RateOne  = 17'd65536;
  localparam logic [FileBytesW-1:0] BytesMax = '1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  gc_victim_file_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers and of the scan totals.
  // Registers start at their reset values so the first scan checks the defaults.
  // ---------------------------------------------------------------------------
  cfg_t regs_shadow = '{MAX_RATE_RST, SMALL_BYTES_RST, TARGET_BYTES_RST,
                        MIN_FILES_RST, MIN_BYTES_RST};

  logic [CountW-1:0]    cand_count      = '0;
  logic [BytesTotW-1:0] moved_bytes     = '0;
  logic [BytesTotW-1:0] low_rate_total  = '0;  // bytes from files below the 13/20 ratio
  logic [CountW-1:0]    high_rate_files = '0;  // candidates at or above the 13/20 ratio
  logic [PagesTotW-1:0] moved_pages     = '0;
  logic                 stop_seen       = 1'b0;

  in_t  file_backlog[$];     // files waiting for the driver
  out_t awaited_tallies[$];  // predicted results, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;
  int files_checked  = 0;
  int scans_closed   = 0;
  int scans_stopped  = 0;
  int scans_compact  = 0;
  int verdict_hist[4] = '{0, 0, 0, 0};

  // Classify one file against the current scan state and return what the
  // block should report for it. Updates the scan totals as a side effect.
  function automatic out_t judge_file(in_t f);
    logic [56:0] live_q16;
    logic [56:0] rate_span;
    logic [45:0] live_x20;
    logic [45:0] file_x13;
    logic [48:0] byte_sum;
    logic [32:0] page_sum;
    logic        low_rate;
    logic        chosen;
    logic        stop_now;
    out_t        r;
    r = '0;
    if (stop_seen) begin
      r.verdict = VERDICT_IGNORED;
    end else begin
      // live/file < rate/65536, cross-multiplied so nothing is rounded
      live_q16  = {1'b0, f.live_bytes, 16'b0};
      rate_span = regs_shadow.max_valid_rate_q16 * f.file_bytes;
      if (f.live_bytes == '0) begin
        low_rate = (regs_shadow.max_valid_rate_q16 != '0);
      end else begin
        low_rate = (f.file_bytes != '0) && (live_q16 < rate_span);
      end
      chosen = !f.being_written &&
               (low_rate || f.file_bytes < regs_shadow.small_file_bytes ||
                regs_shadow.max_valid_rate_q16 >= RateOne);
      if (!chosen) begin
        r.verdict = VERDICT_SKIP;
      end else if (f.live_bytes == '0) begin
        r.verdict = VERDICT_EMPTY;
      end else begin
        r.verdict = VERDICT_CAND;
        if (cand_count != '1) cand_count = cand_count + 1'b1;
        page_sum    = moved_pages + f.live_pages;
        moved_pages = page_sum[32] ? '1 : page_sum[31:0];
        byte_sum    = moved_bytes + f.live_bytes;
        moved_bytes = byte_sum[48] ? '1 : byte_sum[47:0];
        // 0.65 threshold as live*20 < file*13
        live_x20 = f.live_bytes * 46'd20;
        file_x13 = f.file_bytes * 46'd13;
        if (live_x20 < file_x13) begin
          byte_sum       = low_rate_total + f.live_bytes;
          low_rate_total = byte_sum[48] ? '1 : byte_sum[47:0];
        end else if (high_rate_files != '1) begin
          high_rate_files = high_rate_files + 1'b1;
        end
        // once any dense file is taken, only the sparse bytes count toward the target
        if (high_rate_files == '0) begin
          stop_now = moved_bytes >= regs_shadow.target_file_bytes;
        end else begin
          stop_now = low_rate_total >= regs_shadow.target_file_bytes;
        end
        if (stop_now && cand_count >= MIN_CANDIDATES) stop_seen = 1'b1;
      end
    end
    r.selection_stopped = stop_seen;
    r.candidates_so_far = cand_count;
    r.bytes_to_move     = moved_bytes;
    r.pages_to_move     = moved_pages;
    if (f.last_file) begin
      r.scan_done      = 1'b1;
      r.run_compaction = (cand_count >= regs_shadow.min_files) ||
                         (cand_count >= MIN_CANDIDATES &&
                          moved_bytes >= regs_shadow.min_bytes);
      // end of scan: totals clear, registers stay
      cand_count      = '0;
      moved_bytes     = '0;
      low_rate_total  = '0;
      high_rate_files = '0;
      moved_pages     = '0;
      stop_seen       = 1'b0;
    end
    return r;
  endfunction

  // Random 40-bit value with a random magnitude, so small and huge sizes both show up.
  function automatic logic [FileBytesW-1:0] scaled40();
    int unsigned e;
    logic [63:0] v;
    e = $urandom_range(40, 0);
    v = {$urandom, $urandom};
    return v[39:0] >> (40 - e);
  endfunction

  // One random file. Live bytes mostly track the file size, with some aimed at
  // the rate ceiling and the 13/20 ratio threshold, and some noise where live exceeds size.
  function automatic in_t random_file(logic last_one);
    in_t         f;
    logic [63:0] wide;
    logic [31:0] page_bits;
    f.file_bytes = scaled40();
    case ($urandom_range(9))
      0: wide = '0;
      1: wide = {24'b0, f.file_bytes};
      2: wide = {24'b0, scaled40()};
      3: wide = (({24'b0, f.file_bytes} * regs_shadow.max_valid_rate_q16) >> 16) +
                $urandom_range(1);
      4: wide = ({24'b0, f.file_bytes} * $urandom_range(660, 640)) / 1000;
      default: wide = ({24'b0, f.file_bytes} * $urandom_range(1000)) / 1000;
    endcase
    f.live_bytes    = wide[39:0];
    page_bits       = $urandom;
    f.live_pages    = ($urandom_range(2) == 0) ? page_bits[23:0] : f.live_bytes[35:12];
    f.being_written = ($urandom_range(9) == 0);
    f.last_file     = last_one;
    return f;
  endfunction

  function automatic void add_file(logic [FileBytesW-1:0] fb, logic [FileBytesW-1:0] lb,
                                   logic [LivePagesW-1:0] lp, logic wr, logic last_one);
    in_t f;
    f.file_bytes    = fb;
    f.live_bytes    = lb;
    f.live_pages    = lp;
    f.being_written = wr;
    f.last_file     = last_one;
    file_backlog.push_back(f);
  endfunction

  function automatic void set_idle(idle_mode_t m);
    send_idle_pct  = (m == IDLE_SEND) ? 79 : (m == IDLE_BOTH) ? 34 : 0;
    recv_stall_pct = (m == IDLE_RECV) ? 79 : (m == IDLE_BOTH) ? 34 : 0;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < MaxShown) begin
      $display("%0t ns mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Config writes: one register per cycle, no handshake.
  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  // Only called while the block is idle, so the shadow can change at once.
  task automatic program_regs(cfg_t c);
    regs_shadow = c;
    write_reg(REG_MAX_RATE, CfgDataW'(c.max_valid_rate_q16));
    write_reg(REG_SMALL_BYTES, c.small_file_bytes);
    write_reg(REG_TARGET_BYTES, c.target_file_bytes);
    write_reg(REG_MIN_FILES, CfgDataW'(c.min_files));
    write_reg(REG_MIN_BYTES, c.min_bytes);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for the backlog to go out and every predicted result to come back.
  // Checked on the falling edge so the queues and valid are settled.
  task automatic drain();
    while (file_backlog.size() != 0 || in_valid || awaited_tallies.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pulls from the backlog. A new beat is offered only when the slot
  // is free (nothing held, or the held beat is taken at this edge), so valid
  // never drops with a beat pending. The prediction is made at acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_tallies.push_back(judge_file(in_data));
      end
      if (!in_valid || in_ready) begin
        if (file_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= file_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result beat is checked field by field against the oldest
  // prediction; ready toggles at random per the current stall rate.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_tallies.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding",
                        64'(out_data.bytes_to_move), '0);
        end else begin
          want = awaited_tallies.pop_front();
          files_checked++;
          if (out_data.verdict !== want.verdict)
            flag_mismatch("verdict", 64'(out_data.verdict), 64'(want.verdict));
          if (out_data.selection_stopped !== want.selection_stopped)
            flag_mismatch("selection_stopped", 64'(out_data.selection_stopped),
                          64'(want.selection_stopped));
          if (out_data.candidates_so_far !== want.candidates_so_far)
            flag_mismatch("candidates_so_far", 64'(out_data.candidates_so_far),
                          64'(want.candidates_so_far));
          if (out_data.bytes_to_move !== want.bytes_to_move)
            flag_mismatch("bytes_to_move", 64'(out_data.bytes_to_move),
                          64'(want.bytes_to_move));
          if (out_data.pages_to_move !== want.pages_to_move)
            flag_mismatch("pages_to_move", 64'(out_data.pages_to_move),
                          64'(want.pages_to_move));
          if (out_data.run_compaction !== want.run_compaction)
            flag_mismatch("run_compaction", 64'(out_data.run_compaction),
                          64'(want.run_compaction));
          if (out_data.scan_done !== want.scan_done)
            flag_mismatch("scan_done", 64'(out_data.scan_done), 64'(want.scan_done));
          verdict_hist[want.verdict]++;
          if (want.scan_done) begin
            scans_closed++;
            if (want.selection_stopped) scans_stopped++;
            if (want.run_compaction) scans_compact++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any beat on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("watchdog: no beat in %0d cycles, %0d results outstanding",
               QuietLimit, awaited_tallies.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t        c;
    int unsigned rnd;
    int unsigned span;
    int unsigned queued;
    set_idle(IDLE_NONE);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: rate ~0.35, small 1 MiB, target and min_bytes 128 MiB.
    add_file(40'd0, 40'd0, 24'd0, 1'b0, 1'b0);                // empty file
    add_file(40'd0, 40'd5, 24'd1, 1'b0, 1'b0);                // zero size: small, dense
    add_file(BytesMax, BytesMax, '1, 1'b0, 1'b0);             // full, skipped
    add_file(40'd100, 40'd50, 24'd3, 1'b1, 1'b0);             // being written
    add_file(40'd10000000, 40'd1000000, 24'd256, 1'b0, 1'b0); // sparse candidate
    add_file(40'd200000000, 40'd150000000, 24'd9, 1'b0, 1'b0);
    add_file(BytesMax, 40'h40000000, '1, 1'b0, 1'b0);         // crosses target, stops
    add_file(40'd10, 40'd1, 24'd1, 1'b0, 1'b0);               // ignored after stop
    add_file(40'd1, 40'd1, 24'd1, 1'b0, 1'b1);                // last, compaction
    add_file(BytesMax, BytesMax, 24'd7, 1'b0, 1'b1);          // lone last, nothing chosen
    drain();

    // Rate exactly one half: equality is not below the ceiling.
    c = '{17'd32768, 40'd0, BytesMax, 16'd3, BytesMax};
    program_regs(c);
    add_file(40'd2000, 40'd1000, 24'd4, 1'b0, 1'b0);
    add_file(40'd2000, 40'd999, 24'd4, 1'b0, 1'b0);
    add_file(40'd100, 40'd0, 24'd0, 1'b0, 1'b0);
    add_file(40'd0, 40'd7, 24'd2, 1'b0, 1'b1);                // zero size never low rate
    drain();

    // Everything at zero: empty files no longer count as low rate.
    c = '{17'd0, 40'd0, 40'd0, 16'd0, 40'd0};
    program_regs(c);
    add_file(40'd100, 40'd0, 24'd0, 1'b0, 1'b0);
    add_file(40'h8000000000, 40'd1, 24'd1, 1'b0, 1'b1);
    drain();

    // Rate 1.0 selects all; the 13/20 ratio threshold; target 0 stops at two candidates.
    c = '{RateOne, BytesMax, 40'd0, 16'hFFFF, 40'd0};
    program_regs(c);
    add_file(40'd20, 40'd13, 24'd1, 1'b0, 1'b0);
    add_file(40'd20, 40'd12, 24'd1, 1'b0, 1'b0);
    add_file(40'd0, 40'd0, 24'd0, 1'b1, 1'b0);
    add_file(40'd5, 40'd5, 24'd5, 1'b0, 1'b1);
    add_file(40'd0, 40'd0, 24'd0, 1'b1, 1'b1);
    drain();

    // Random scans under changing registers and every idle pattern.
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        c = '{17'd0, 40'd0, 40'd0, 16'd0, 40'd0};
      end else if (p == 1) begin
        c = '{RateOne, BytesMax, BytesMax, 16'hFFFF, BytesMax};
      end else begin
        rnd = $urandom_range(65536);
        case ($urandom_range(3))
          0: c.max_valid_rate_q16 = 17'd65535;
          1: c.max_valid_rate_q16 = 17'd1;
          default: c.max_valid_rate_q16 = rnd[16:0];
        endcase
        c.small_file_bytes  = scaled40();
        c.target_file_bytes = scaled40();
        rnd                 = $urandom_range(20);
        c.min_files         = rnd[15:0];
        c.min_bytes         = scaled40();
      end
      program_regs(c);
      set_idle(idle_mode_t'(p % 4));
      queued = 0;
      while (queued < PhaseFiles) begin
        span = ($urandom_range(7) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
        for (int k = 0; k < span; k++) begin
          file_backlog.push_back(random_file(k == span - 1));
        end
        queued += span;
      end
      drain();
    end

    // Saturation: dense files never reach the target, so totals keep growing.
    c = '{RateOne, 40'd0, BytesMax, 16'hFFFF, BytesMax};
    program_regs(c);
    set_idle(IDLE_NONE);
    for (int k = 0; k < ByteSatFiles; k++) begin
      add_file(BytesMax, BytesMax, '1, 1'b0, k == ByteSatFiles - 1);
    end
    for (int k = 0; k < TailFiles; k++) begin
      rnd = $urandom_range(1000, 1);
      add_file(FileBytesW'(rnd), FileBytesW'(rnd), LivePagesW'(rnd), 1'b0,
               k == TailFiles - 1);
    end
    drain();

    if (awaited_tallies.size() != 0) begin
      flag_mismatch("results never delivered", '0, 64'(awaited_tallies.size()));
    end
    $display("checked %0d file results over %0d scans, %0d stopped early, %0d compacting",
             files_checked, scans_closed, scans_stopped, scans_compact);
    $display("verdicts: skip %0d, candidate %0d, empty %0d, ignored %0d; %0d mismatches",
             verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3], mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/gcvfs_pkg.sv
hw/rtl/gcvfs_skid.sv
hw/rtl/gcvfs_classify.sv
hw/rtl/gcvfs_accum.sv
hw/rtl/gc_victim_file_selector.sv
verif/testbench.sv
